// ===== rtl/core/rdc_pkg.sv =====
// Shared types and constants for the radix digit converter.
// No dependencies; imported by every module of the converter.
`default_nettype none

package rdc_pkg;

  localparam int unsigned IN_DIGITS_DEF  = 32;
  localparam int unsigned OUT_DIGITS_DEF = 64;

  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned BASE_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 2'd1;

  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 9'd256;
  localparam logic [BASE_W-1:0] TARGET_BASE_RST = 9'd94;
  localparam logic [BASE_W-1:0] SOURCE_BASE_MIN = 9'd2;
  localparam logic [BASE_W-1:0] TARGET_BASE_MIN = 9'd16;
  localparam logic [BASE_W-1:0] BASE_MAX        = 9'd256;

  typedef enum logic [2:0] {
    S_IDLE,   // collecting source digits
    S_FETCH,  // read one stored digit
    S_MUL,    // acc = acc * sb + digit, one byte limb per cycle
    S_CHECK,  // zero value test
    S_DIV,    // acc = acc / tb, one quotient bit per cycle
    S_STORE,  // store remainder as result digit
    S_RD,     // read result digit for output
    S_OUT     // result beat on the master side
  } rdc_state_e;

  typedef struct packed {
    logic src_wr;
    logic src_rd;
    logic acc_clr;
    logic acc_mul;
    logic mul_first;
    logic acc_div;
    logic rem_clr;
    logic res_wr;
    logic res_zero;
    logic res_rd;
  } rdc_cmd_t;

  typedef struct packed {
    logic acc_zero;
  } rdc_status_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] v,
                                                   input logic [BASE_W-1:0] lo);
    logic [BASE_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rdc_dpath.sv =====
// Datapath of the radix digit converter: digit stores, wide accumulator,
// byte-serial multiply-add and bit-serial divider. Depends on rdc_pkg.
`default_nettype none

module rdc_dpath #(
  parameter int unsigned IN_DIGITS  = rdc_pkg::IN_DIGITS_DEF,
  parameter int unsigned OUT_DIGITS = rdc_pkg::OUT_DIGITS_DEF,
  parameter int unsigned IAW        = 5,
  parameter int unsigned OAW        = 6
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire rdc_pkg::rdc_cmd_t            cmd_i,
  input  wire [IAW-1:0]                     src_addr_i,
  input  wire [OAW-1:0]                     res_addr_i,
  input  wire [rdc_pkg::DIGIT_W-1:0]        digit_i,
  input  wire [rdc_pkg::BASE_W-1:0]         sb_i,
  input  wire [rdc_pkg::BASE_W-1:0]         tb_i,
  output rdc_pkg::rdc_status_t              status_o,
  output logic [rdc_pkg::DIGIT_W-1:0]       digit_o
);
  import rdc_pkg::*;

  localparam int unsigned ACC_W = DIGIT_W * IN_DIGITS;

  logic [DIGIT_W-1:0] src_mem [IN_DIGITS];
  logic [DIGIT_W-1:0] res_mem [OUT_DIGITS];
  logic [DIGIT_W-1:0] src_rd_q;
  logic [DIGIT_W-1:0] res_rd_q;

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [BASE_W-1:0]  carry_q, carry_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;

  logic [BASE_W-1:0]        cin;
  logic [DIGIT_W+BASE_W-1:0] prod;
  logic [ACC_W+DIGIT_W-1:0] rot;
  logic [BASE_W-1:0]        rs;
  logic [BASE_W-1:0]        diff;
  logic                     ge;

  // digit stores; neither needs a reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.src_wr) begin
      src_mem[src_addr_i] <= digit_i;
    end
    if (cmd_i.src_rd) begin
      src_rd_q <= src_mem[src_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_wr) begin
      res_mem[res_addr_i] <= cmd_i.res_zero ? '0 : rem_q;
    end
    if (cmd_i.res_rd) begin
      res_rd_q <= res_mem[res_addr_i];
    end
  end

  always_comb begin
    // multiply-add on the low byte; the result rotates in at the top
    cin  = cmd_i.mul_first ? {1'b0, src_rd_q} : carry_q;
    prod = (DIGIT_W + BASE_W)'(acc_q[DIGIT_W-1:0]) * (DIGIT_W + BASE_W)'(sb_i)
           + (DIGIT_W + BASE_W)'(cin);
    rot  = {prod[DIGIT_W-1:0], acc_q};
    // restoring division step, msb of acc into the remainder
    rs   = {rem_q, acc_q[ACC_W-1]};
    ge   = (rs >= tb_i);
    diff = rs - tb_i;

    acc_d   = acc_q;
    carry_d = carry_q;
    rem_d   = rem_q;
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (cmd_i.acc_mul) begin
      acc_d   = rot[ACC_W+DIGIT_W-1:DIGIT_W];
      carry_d = prod[DIGIT_W+BASE_W-1:DIGIT_W];
    end else if (cmd_i.acc_div) begin
      acc_d = {acc_q[ACC_W-2:0], ge};
      rem_d = ge ? diff[DIGIT_W-1:0] : rs[DIGIT_W-1:0];
    end
    if (cmd_i.rem_clr) begin
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      carry_q <= '0;
      rem_q   <= '0;
    end else begin
      acc_q   <= acc_d;
      carry_q <= carry_d;
      rem_q   <= rem_d;
    end
  end

  assign status_o.acc_zero = (acc_q == '0);
  assign digit_o           = res_rd_q;

endmodule

`default_nettype wire

// ===== rtl/core/rdc_ctrl.sv =====
// Controller of the radix digit converter: sequences collection, conversion
// and output, and holds all counters. Depends on rdc_pkg.
`default_nettype none

module rdc_ctrl #(
  parameter int unsigned IN_DIGITS  = rdc_pkg::IN_DIGITS_DEF,
  parameter int unsigned OUT_DIGITS = rdc_pkg::OUT_DIGITS_DEF,
  parameter int unsigned IAW        = 5,
  parameter int unsigned OAW        = 6
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_last_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  out_last_o,
  output logic                  out_ovf_o,
  output rdc_pkg::rdc_cmd_t     cmd_o,
  output logic [IAW-1:0]        src_addr_o,
  output logic [OAW-1:0]        res_addr_o,
  input  wire rdc_pkg::rdc_status_t status_i
);
  import rdc_pkg::*;

  localparam int unsigned ACC_W = DIGIT_W * IN_DIGITS;
  localparam int unsigned CNT_W = $clog2(IN_DIGITS + 1);
  localparam int unsigned BW    = $clog2(ACC_W);
  localparam int unsigned NMAX  = (2 * IN_DIGITS > OUT_DIGITS) ? 2 * IN_DIGITS : OUT_DIGITS;
  localparam int unsigned N_W   = $clog2(NMAX + 1);

  rdc_state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [IAW-1:0]   limb_q, limb_d;
  logic [BW-1:0]    bit_q, bit_d;
  logic [N_W-1:0]   n_q, n_d;
  logic [OAW-1:0]   k_q, k_d;
  logic             in_ovf_q, in_ovf_d;
  logic             ovf_q, ovf_d;

  logic [N_W-1:0]   n_inc;
  logic             long_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      limb_q   <= '0;
      bit_q    <= '0;
      n_q      <= '0;
      k_q      <= '0;
      in_ovf_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      limb_q   <= limb_d;
      bit_q    <= bit_d;
      n_q      <= n_d;
      k_q      <= k_d;
      in_ovf_q <= in_ovf_d;
      ovf_q    <= ovf_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    limb_d   = limb_q;
    bit_d    = bit_q;
    n_d      = n_q;
    k_d      = k_q;
    in_ovf_d = in_ovf_q;
    ovf_d    = ovf_q;

    cmd_o      = '0;
    src_addr_o = idx_q[IAW-1:0];
    res_addr_o = k_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    n_inc    = n_q + 1'b1;
    long_res = (n_inc > N_W'(OUT_DIGITS));

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        src_addr_o = cnt_q[IAW-1:0];
        if (in_valid_i) begin
          if (cnt_q < CNT_W'(IN_DIGITS)) begin
            cmd_o.src_wr = 1'b1;
            cnt_d        = cnt_q + 1'b1;
          end else begin
            in_ovf_d = 1'b1;
          end
          if (in_last_i) begin
            cmd_o.acc_clr = 1'b1;
            idx_d         = '0;
            n_d           = '0;
            state_d       = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd_o.src_rd = 1'b1;
        limb_d       = '0;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.acc_mul   = 1'b1;
        cmd_o.mul_first = (limb_q == '0);
        limb_d          = limb_q + 1'b1;
        if (limb_q == IAW'(IN_DIGITS - 1)) begin
          idx_d   = idx_q + 1'b1;
          state_d = (idx_q == cnt_q - 1'b1) ? S_CHECK : S_FETCH;
        end
      end
      S_CHECK: begin
        if (status_i.acc_zero) begin
          // zero value: single digit 0
          cmd_o.res_wr   = 1'b1;
          cmd_o.res_zero = 1'b1;
          res_addr_o     = '0;
          n_d            = N_W'(1);
          k_d            = '0;
          ovf_d          = in_ovf_q;
          state_d        = S_RD;
        end else begin
          cmd_o.rem_clr = 1'b1;
          bit_d         = '0;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.acc_div = 1'b1;
        bit_d         = bit_q + 1'b1;
        if (bit_q == BW'(ACC_W - 1)) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        // digits past the buffer are counted but not kept
        if (n_q < N_W'(OUT_DIGITS)) begin
          cmd_o.res_wr = 1'b1;
          res_addr_o   = n_q[OAW-1:0];
        end
        n_d = n_inc;
        if (status_i.acc_zero) begin
          ovf_d   = in_ovf_q | long_res;
          k_d     = long_res ? OAW'(OUT_DIGITS - 1) : OAW'(n_q);
          state_d = S_RD;
        end else begin
          cmd_o.rem_clr = 1'b1;
          bit_d         = '0;
          state_d       = S_DIV;
        end
      end
      S_RD: begin
        cmd_o.res_rd = 1'b1;
        res_addr_o   = k_q;
        state_d      = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (k_q == '0) begin
            cnt_d    = '0;
            in_ovf_d = 1'b0;
            state_d  = S_IDLE;
          end else begin
            k_d     = k_q - 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_last_o = (k_q == '0);
  assign out_ovf_o  = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/core/radix_digit_converter_core.sv =====
// Radix digit converter top level: stream ports, configuration registers,
// controller and datapath. Depends on rdc_pkg, rdc_ctrl and rdc_dpath.
// After the last source beat, stored digits are folded in limb by limb, the
// zero test follows and each result digit takes a bit-serial division; output
// stalls can hold each result beat. Input is stalled from the last beat until
// the last result beat. Async reset clears control state and the accumulator.
`default_nettype none

module radix_digit_converter_core #(
  parameter int unsigned IN_DIGITS  = rdc_pkg::IN_DIGITS_DEF,
  parameter int unsigned OUT_DIGITS = rdc_pkg::OUT_DIGITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // source digits
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [rdc_pkg::DIGIT_W-1:0]       s_axis_tdata,  // [7:0] digit_in
  input  wire                              s_axis_tlast,  // last_in
  // target digits
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [rdc_pkg::DIGIT_W-1:0]      m_axis_tdata,  // [7:0] digit_out
  output logic                             m_axis_tlast,  // last_out
  output logic                             m_axis_tuser,  // [0] overflow
  // configuration writes
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [rdc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [rdc_pkg::BASE_W-1:0]        cfg_data_i
);
  import rdc_pkg::*;

  localparam int unsigned IAW = (IN_DIGITS > 1) ? $clog2(IN_DIGITS) : 1;
  localparam int unsigned OAW = (OUT_DIGITS > 1) ? $clog2(OUT_DIGITS) : 1;

  logic [BASE_W-1:0] src_base_q;
  logic [BASE_W-1:0] tgt_base_q;
  logic [BASE_W-1:0] sb;
  logic [BASE_W-1:0] tb;

  rdc_cmd_t    cmd;
  rdc_status_t status;
  logic [IAW-1:0] src_addr;
  logic [OAW-1:0] res_addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_base_q <= SOURCE_BASE_RST;
      tgt_base_q <= TARGET_BASE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        REG_SOURCE_BASE: src_base_q <= cfg_data_i;
        REG_TARGET_BASE: tgt_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // registers keep the written bits; the bases are saturated where used
  assign sb = clamp_base(src_base_q, SOURCE_BASE_MIN);
  assign tb = clamp_base(tgt_base_q, TARGET_BASE_MIN);

  rdc_ctrl #(
    .IN_DIGITS  (IN_DIGITS),
    .OUT_DIGITS (OUT_DIGITS),
    .IAW        (IAW),
    .OAW        (OAW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser),
    .cmd_o       (cmd),
    .src_addr_o  (src_addr),
    .res_addr_o  (res_addr),
    .status_i    (status)
  );

  rdc_dpath #(
    .IN_DIGITS  (IN_DIGITS),
    .OUT_DIGITS (OUT_DIGITS),
    .IAW        (IAW),
    .OAW        (OAW)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .src_addr_i (src_addr),
    .res_addr_i (res_addr),
    .digit_i    (s_axis_tdata),
    .sb_i       (sb),
    .tb_i       (tb),
    .status_o   (status),
    .digit_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire
